/* design/bacc_pkg.sv */
// Shared types and constants for the bounded accumulator.
`default_nettype none

package bacc_pkg;

  localparam int unsigned CFG_INDEX_WIDTH = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_BOUND = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_BOUND = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRAP_ENABLE = 2'd2;

  // result kinds carried on tuser
  localparam logic PORT_VALUE = 1'b0;
  localparam logic PORT_CARRY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_HI,
    S_DIV_HI,
    S_WRAP_HI,
    S_EMIT_HI,
    S_CHK_LO,
    S_DIV_LO,
    S_WRAP_LO,
    S_EMIT_LO,
    S_EMIT_VAL
  } state_t;

  typedef struct packed {
    logic load_v;      // take the input word into the working value
    logic clamp_hi;
    logic clamp_lo;
    logic div_start;   // load divider with the bound excess
    logic div_lo;      // divider works on the lower bound
    logic div_step;
    logic wrap_hi;
    logic wrap_lo;
    logic emit_carry;
    logic emit_value;  // also commits the accumulator
  } cmd_t;

  typedef struct packed {
    logic over_hi;
    logic under_lo;
    logic wrap_hi_ok;
    logic wrap_lo_ok;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* design/bounded_accumulator_wrap_clamp.sv */
// Each wrap runs VALUE_WIDTH + 1 remainder steps of the shared bit-serial remainder divider.
// One word in flight at a time: a new input word is taken only in idle, after the value word
// has been handed to the output register; an output stall holds the word in flight.
// Synchronous active-low reset: accumulator 0, bounds at the full signed range,
// wrap off, output empty.
`default_nettype none

module bounded_accumulator_wrap_clamp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [bacc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire  [VALUE_WIDTH-1:0]                cfg_wdata,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [((VALUE_WIDTH+7)/8)*8-1:0]      in_tdata,   // amount
  input  wire                                   in_tuser,   // mode
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]      out_tdata,  // result_value
  output logic                                  out_tuser,  // port
  output logic                                  out_tlast
);

  localparam int unsigned DW = ((VALUE_WIDTH + 7) / 8) * 8;

  bacc_pkg::cmd_t         cmd;
  bacc_pkg::sts_t         sts;
  logic                   idle;
  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] out_value;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;

  bacc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  bacc_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser),
    .in_amount  (in_tdata[VALUE_WIDTH-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_port   (out_tuser),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = DW'(out_value);

endmodule

`default_nettype wire

/* design/bacc_ctrl.sv */
// Controller state machine for the bounded accumulator.
`default_nettype none

module bacc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_fire,
  input  bacc_pkg::sts_t   sts,
  output logic             idle,
  output bacc_pkg::cmd_t   cmd
);

  bacc_pkg::state_t state_r;
  bacc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bacc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    idle      = 1'b0;
    case (state_r)
      bacc_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load_v = 1'b1;
          state_nxt  = bacc_pkg::S_CHK_HI;
        end
      end
      bacc_pkg::S_CHK_HI: begin
        if (sts.over_hi && sts.wrap_hi_ok) begin
          cmd.div_start = 1'b1;
          state_nxt     = bacc_pkg::S_DIV_HI;
        end else begin
          cmd.clamp_hi = sts.over_hi;
          state_nxt    = bacc_pkg::S_CHK_LO;
        end
      end
      bacc_pkg::S_DIV_HI: begin
        if (sts.div_done) begin
          state_nxt = bacc_pkg::S_WRAP_HI;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      bacc_pkg::S_WRAP_HI: begin
        cmd.wrap_hi = 1'b1;
        state_nxt   = bacc_pkg::S_EMIT_HI;
      end
      bacc_pkg::S_EMIT_HI: begin
        if (sts.out_free) begin
          cmd.emit_carry = 1'b1;
          state_nxt      = bacc_pkg::S_CHK_LO;
        end
      end
      bacc_pkg::S_CHK_LO: begin
        if (sts.under_lo && sts.wrap_lo_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_lo    = 1'b1;
          state_nxt     = bacc_pkg::S_DIV_LO;
        end else begin
          cmd.clamp_lo = sts.under_lo;
          state_nxt    = bacc_pkg::S_EMIT_VAL;
        end
      end
      bacc_pkg::S_DIV_LO: begin
        if (sts.div_done) begin
          state_nxt = bacc_pkg::S_WRAP_LO;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      bacc_pkg::S_WRAP_LO: begin
        cmd.wrap_lo = 1'b1;
        state_nxt   = bacc_pkg::S_EMIT_LO;
      end
      bacc_pkg::S_EMIT_LO: begin
        if (sts.out_free) begin
          cmd.emit_carry = 1'b1;
          state_nxt      = bacc_pkg::S_EMIT_VAL;
        end
      end
      bacc_pkg::S_EMIT_VAL: begin
        if (sts.out_free) begin
          cmd.emit_value = 1'b1;
          state_nxt      = bacc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bacc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/bacc_dp.sv */
// Datapath: bound registers, accumulator, remainder divider and output register.
`default_nettype none

module bacc_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       cfg_we,
  input  wire  [bacc_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  wire  [VALUE_WIDTH-1:0]                    cfg_wdata,
  input  wire                                       in_mode,
  input  wire  [VALUE_WIDTH-1:0]                    in_amount,
  input  bacc_pkg::cmd_t                            cmd,
  output bacc_pkg::sts_t                            sts,
  output logic                                      out_tvalid,
  input  wire                                       out_tready,
  output logic                                      out_port,
  output logic [VALUE_WIDTH-1:0]                    out_value,
  output logic                                      out_last
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned XW = W + 1;              // exact sum width
  localparam int unsigned CW = $clog2(W + 2);

  localparam logic signed [XW-1:0] MAX_VAL = {2'b00, {(W-1){1'b1}}};

  logic signed [W-1:0]  lb_r;
  logic signed [W-1:0]  ub_r;
  logic                 wrap_r;
  logic signed [W-1:0]  acc_r;
  logic signed [XW-1:0] v_r;
  logic [XW-1:0]        dvd_r;
  logic [W-1:0]         rem_r;
  logic [CW-1:0]        cnt_r;
  logic                 sel_lo_r;
  logic                 out_valid_r;
  logic                 out_port_r;
  logic [W-1:0]         out_value_r;
  logic                 out_last_r;

  logic signed [XW-1:0] lb_x;
  logic signed [XW-1:0] ub_x;
  logic signed [XW-1:0] acc_x;
  logic [W-1:0]         mag_lb;
  logic [W-1:0]         mag_ub;
  logic [W-1:0]         mag;
  logic [XW-1:0]        excess;
  logic [XW-1:0]        rem_sh;
  logic [XW-1:0]        rem_sub;
  logic [W-1:0]         off;
  logic signed [XW-1:0] lo_wrapped;
  logic                 out_free;

  assign lb_x = {lb_r[W-1], lb_r};
  assign ub_x = {ub_r[W-1], ub_r};

  // magnitude of a bound; the most negative value maps to 2^(W-1)
  assign mag_lb = lb_r[W-1] ? (~lb_r + W'(1)) : lb_r;
  assign mag_ub = ub_r[W-1] ? (~ub_r + W'(1)) : ub_r;
  assign mag    = sel_lo_r ? mag_lb : mag_ub;

  assign excess = cmd.div_lo ? XW'(lb_x - v_r) : XW'(v_r - ub_x);

  // one restoring step, remainder only
  assign rem_sh  = {rem_r, dvd_r[XW-1]};
  assign rem_sub = rem_sh - {1'b0, mag};

  assign off        = (rem_r == '0) ? '0 : (mag - rem_r);
  assign lo_wrapped = lb_x + $signed({1'b0, off});

  // sign-extend accumulator explicitly
  assign acc_x = {acc_r[W-1], acc_r};

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts            = '0;
    sts.over_hi    = v_r > ub_x;
    sts.under_lo   = v_r < lb_x;
    sts.wrap_hi_ok = wrap_r && (ub_r != '0);
    sts.wrap_lo_ok = wrap_r && (lb_r != '0);
    sts.div_done   = (cnt_r == '0);
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r   <= {1'b1, {(W-1){1'b0}}};
      ub_r   <= {1'b0, {(W-1){1'b1}}};
      wrap_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bacc_pkg::REG_LOWER_BOUND: lb_r   <= cfg_wdata;
        bacc_pkg::REG_UPPER_BOUND: ub_r   <= cfg_wdata;
        bacc_pkg::REG_WRAP_ENABLE: wrap_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.emit_value) begin
      acc_r <= v_r[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_v) begin
      v_r <= in_mode ? (acc_x + {in_amount[W-1], in_amount})
                     : {in_amount[W-1], in_amount};
    end else if (cmd.clamp_hi) begin
      v_r <= ub_x;
    end else if (cmd.clamp_lo) begin
      v_r <= lb_x;
    end else if (cmd.wrap_hi) begin
      v_r <= ub_x - $signed({1'b0, off});
    end else if (cmd.wrap_lo) begin
      v_r <= (lo_wrapped > MAX_VAL) ? MAX_VAL : lo_wrapped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= CW'(XW);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r    <= excess;
      rem_r    <= '0;
      sel_lo_r <= cmd.div_lo;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[XW-2:0], 1'b0};
      rem_r <= rem_sh >= {1'b0, mag} ? rem_sub[W-1:0] : rem_sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_carry || cmd.emit_value) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_carry || cmd.emit_value) begin
      out_port_r  <= cmd.emit_carry ? bacc_pkg::PORT_CARRY : bacc_pkg::PORT_VALUE;
      out_value_r <= v_r[W-1:0];
      out_last_r  <= cmd.emit_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_port   = out_port_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

/* tb/bounded_accumulator_wrap_clamp_test.sv */
// Self-checking testbench for the bounded clamp/wrap accumulator.
`timescale 1ns / 1ps

module bounded_accumulator_wrap_clamp_test;

  localparam int VW = 32;
  localparam int BW = ((VW + 7) / 8) * 8;
  localparam int IW = bacc_pkg::CFG_INDEX_WIDTH;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_ADD = 1'b1;
  localparam longint ACC_MAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 35;
  localparam int SQUEEZE_PHASE = 4;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * VW + 14;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic          port;
    logic [VW-1:0] value;
    logic          last;
  } acc_word_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [IW-1:0]              sel;          // mode for items, index for registers
    logic [VW-1:0]              data;
    logic                       typed;
    logic [VW-1:0]              typed_value;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [VW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [BW-1:0] in_tdata = '0;   // amount
  logic in_tuser = 1'b0;          // mode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [BW-1:0] out_tdata;       // result_value
  logic out_tuser;                // port
  logic out_tlast;

  // typed-in expectation travels alongside the offered word
  logic row_typed = 1'b0;
  logic [VW-1:0] row_typed_value = '0;

  // predictor copy of the block
  longint acc_m, lo_m, hi_m;
  logic wrap_m;
  acc_word_t owed_q[$];
  int words_owed = 0;

  int words_in = 0, words_out = 0, carries_seen = 0, reg_writes = 0;
  int mismatches = 0;
  int squeezes_asked = 0, squeezes_done = 0;
  bit sink_idle_on = 1'b1;
  bit src_idle_on = 1'b1;
  plan_row_t plan[$];

  bounded_accumulator_wrap_clamp #(.VALUE_WIDTH(VW)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void owe(logic port, longint v, logic last);
    acc_word_t w;
    w.port = port;
    w.value = v[VW-1:0];
    w.last = last;
    owed_q.push_back(w);
  endfunction

  // upper check, then lower check, then the value word
  function automatic void step_accumulator(logic mode, logic signed [VW-1:0] amount,
                                           logic typed, logic [VW-1:0] typed_value);
    longint v;
    u64_t mag, rem, off;
    v = (mode == MODE_ADD) ? acc_m + longint'(amount) : longint'(amount);
    if (v > hi_m) begin
      mag = (hi_m < 0) ? u64_t'(-hi_m) : u64_t'(hi_m);
      if (wrap_m && mag != 0) begin
        rem = u64_t'(v - hi_m) % mag;
        off = (rem != 0) ? mag - rem : 0;
        v = hi_m - longint'(off);
        owe(bacc_pkg::PORT_CARRY, v, 1'b0);
      end else begin
        v = hi_m;
      end
    end
    if (v < lo_m) begin
      mag = (lo_m < 0) ? u64_t'(-lo_m) : u64_t'(lo_m);
      if (wrap_m && mag != 0) begin
        rem = u64_t'(lo_m - v) % mag;
        off = (rem != 0) ? mag - rem : 0;
        v = lo_m + longint'(off);
        if (v > ACC_MAX) v = ACC_MAX;   // wrap up past the top saturates
        owe(bacc_pkg::PORT_CARRY, v, 1'b0);
      end else begin
        v = lo_m;
      end
    end
    acc_m = v;
    owe(bacc_pkg::PORT_VALUE, typed ? longint'($signed(typed_value)) : v, 1'b1);
  endfunction

  // model update and checking in one place, all on the same edge as the block
  always @(posedge clk) begin
    acc_word_t w;
    if (!rst_n) begin
      acc_m = 0;
      lo_m = ACC_MIN;
      hi_m = ACC_MAX;
      wrap_m = 1'b0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bacc_pkg::REG_LOWER_BOUND: lo_m = longint'($signed(cfg_wdata));
          bacc_pkg::REG_UPPER_BOUND: hi_m = longint'($signed(cfg_wdata));
          bacc_pkg::REG_WRAP_ENABLE: wrap_m = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        words_in++;
        step_accumulator(in_tuser, in_tdata[VW-1:0], row_typed, row_typed_value);
      end
      if (out_tvalid && out_tready) begin
        words_out++;
        if (out_tuser == bacc_pkg::PORT_CARRY) carries_seen++;
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word %0d: port %0b value %0d last %0b",
                     words_out, out_tuser, $signed(out_tdata[VW-1:0]), out_tlast);
        end else begin
          w = owed_q.pop_front();
          if (out_tuser !== w.port || out_tdata[VW-1:0] !== w.value ||
              out_tlast !== w.last || (out_tdata >> VW) !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result word %0d: expected port %0b value %0d last %0b, ",
                        "got port %0b value %0d last %0b"},
                       words_out, w.port, $signed(w.value), w.last,
                       out_tuser, $signed(out_tdata[VW-1:0]), out_tlast);
          end
        end
      end
    end
    words_owed <= owed_q.size();
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : sink
    int n;
    forever begin
      @(posedge clk);
      if (squeezes_asked != squeezes_done) begin
        squeezes_done++;
        out_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 99) < 20) begin
        n = $urandom_range(1, 9);
        out_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic mode, logic [VW-1:0] amount, logic typed,
                           logic [VW-1:0] typed_value);
    int gap;
    if (src_idle_on && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= BW'(amount);
    row_typed <= typed;
    row_typed_value <= typed_value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  task automatic drive_reg(logic [IW-1:0] index, logic [VW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_regs(logic [VW-1:0] lo, logic [VW-1:0] hi, logic wrap);
    wait_idle();
    drive_reg(bacc_pkg::REG_LOWER_BOUND, lo);
    drive_reg(bacc_pkg::REG_UPPER_BOUND, hi);
    drive_reg(bacc_pkg::REG_WRAP_ENABLE, {(VW-1)'($urandom()), wrap});   // upper bits are don't-care
    cfg_we <= 1'b0;
  endtask

  function automatic plan_row_t item_row(logic mode, logic [VW-1:0] amount, logic typed,
                                         logic [VW-1:0] typed_value);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.sel = IW'(mode);
    r.data = amount;
    r.typed = typed;
    r.typed_value = typed_value;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [IW-1:0] index, logic [VW-1:0] data);
    plan_row_t r;
    r.kind = ROW_REG;
    r.sel = index;
    r.data = data;
    r.typed = 1'b0;
    r.typed_value = '0;
    return r;
  endfunction

  function automatic logic [VW-1:0] pick_bound();
    case ($urandom_range(0, 7))
      0: return VW'(ACC_MIN);
      1: return VW'(ACC_MAX);
      2: return '0;
      3, 4: return VW'($urandom_range(0, 400)) - VW'(200);
      5: return VW'($urandom());
      6: return VW'(ACC_MAX) - VW'($urandom_range(0, 300));
      default: return VW'(ACC_MIN) + VW'($urandom_range(0, 300));
    endcase
  endfunction

  initial begin : stimulus
    logic [VW-1:0] lo_cur, hi_cur, amt, swap;
    logic wrap_cur, mode;
    bit prev_reg;

    // after reset: full range, clamping
    plan.push_back(item_row(MODE_ADD, 32'd0, 1'b1, 32'd0));
    plan.push_back(item_row(MODE_LOAD, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff));
    plan.push_back(item_row(MODE_ADD, 32'd1, 1'b1, 32'h7fff_ffff));
    plan.push_back(item_row(MODE_LOAD, 32'h8000_0000, 1'b1, 32'h8000_0000));
    plan.push_back(item_row(MODE_ADD, 32'hffff_ffff, 1'b1, 32'h8000_0000));
    plan.push_back(item_row(MODE_ADD, 32'h8000_0000, 1'b1, 32'h8000_0000));
    // wrapping over the full range
    plan.push_back(reg_row(bacc_pkg::REG_WRAP_ENABLE, 32'd1));
    plan.push_back(item_row(MODE_LOAD, 32'd5, 1'b1, 32'd5));
    plan.push_back(item_row(MODE_ADD, 32'h7fff_ffff, 1'b0, '0));
    // small symmetric window
    plan.push_back(reg_row(bacc_pkg::REG_LOWER_BOUND, -32'sd100));
    plan.push_back(reg_row(bacc_pkg::REG_UPPER_BOUND, 32'd100));
    plan.push_back(item_row(MODE_LOAD, 32'd250, 1'b0, '0));
    plan.push_back(item_row(MODE_LOAD, -32'sd250, 1'b0, '0));
    plan.push_back(item_row(MODE_LOAD, 32'd100, 1'b1, 32'd100));
    plan.push_back(item_row(MODE_LOAD, 32'd200, 1'b0, '0));
    // zero upper bound while wrapping clamps
    plan.push_back(reg_row(bacc_pkg::REG_UPPER_BOUND, 32'd0));
    plan.push_back(item_row(MODE_LOAD, 32'd7, 1'b1, 32'd0));
    // zero lower bound likewise
    plan.push_back(reg_row(bacc_pkg::REG_LOWER_BOUND, 32'd0));
    plan.push_back(reg_row(bacc_pkg::REG_UPPER_BOUND, 32'd100));
    plan.push_back(item_row(MODE_LOAD, -32'sd5, 1'b1, 32'd0));
    // lower above upper: clamp high, then clamp low
    plan.push_back(reg_row(bacc_pkg::REG_LOWER_BOUND, 32'd50));
    plan.push_back(reg_row(bacc_pkg::REG_UPPER_BOUND, -32'sd50));
    plan.push_back(reg_row(bacc_pkg::REG_WRAP_ENABLE, 32'd0));
    plan.push_back(item_row(MODE_LOAD, 32'd0, 1'b1, 32'd50));
    plan.push_back(reg_row(bacc_pkg::REG_WRAP_ENABLE, 32'd1));
    plan.push_back(item_row(MODE_LOAD, 32'd0, 1'b0, '0));
    // lower wrap lands past the top and saturates
    plan.push_back(reg_row(bacc_pkg::REG_LOWER_BOUND, 32'h7fff_fff0));
    plan.push_back(reg_row(bacc_pkg::REG_UPPER_BOUND, 32'h7fff_ffff));
    plan.push_back(item_row(MODE_LOAD, 32'h8000_0000, 1'b1, 32'h7fff_ffff));
    // lower wrap ends above the upper bound and is not rechecked
    plan.push_back(reg_row(bacc_pkg::REG_LOWER_BOUND, 32'd10));
    plan.push_back(reg_row(bacc_pkg::REG_UPPER_BOUND, 32'd12));
    plan.push_back(item_row(MODE_LOAD, 32'd3, 1'b0, '0));
    plan.push_back(item_row(MODE_ADD, 32'd5, 1'b0, '0));
    // negative upper bound, most negative lower bound
    plan.push_back(reg_row(bacc_pkg::REG_UPPER_BOUND, -32'sd20));
    plan.push_back(reg_row(bacc_pkg::REG_LOWER_BOUND, 32'h8000_0000));
    plan.push_back(item_row(MODE_LOAD, 32'd0, 1'b0, '0));
    plan.push_back(item_row(MODE_ADD, 32'h8000_0000, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    prev_reg = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        if (!prev_reg) wait_idle();
        drive_reg(plan[r].sel, plan[r].data);
      end else begin
        if (prev_reg) cfg_we <= 1'b0;
        send_word(plan[r].sel[0], plan[r].data, plan[r].typed, plan[r].typed_value);
      end
      prev_reg = (plan[r].kind == ROW_REG);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 2) begin
        lo_cur = VW'(ACC_MIN);
        hi_cur = VW'(ACC_MAX);
        wrap_cur = (ph == 0);
      end else begin
        lo_cur = pick_bound();
        hi_cur = pick_bound();
        // mostly an ordered window, sometimes crossed
        if ($urandom_range(0, 4) != 0 && $signed(lo_cur) > $signed(hi_cur)) begin
          swap = lo_cur;
          lo_cur = hi_cur;
          hi_cur = swap;
        end
        wrap_cur = ($urandom_range(0, 3) != 0);
      end
      set_regs(lo_cur, hi_cur, wrap_cur);

      // last phase runs flat out on both sides
      src_idle_on = (ph != RAND_PHASES - 1) && (ph != SQUEEZE_PHASE) &&
                    ($urandom_range(0, 3) != 0);
      sink_idle_on <= (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);

      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == SQUEEZE_PHASE && k == 4) squeezes_asked <= squeezes_asked + 1;
        mode = ($urandom_range(0, 9) < 6) ? MODE_ADD : MODE_LOAD;
        case ($urandom_range(0, 9))
          0, 1: amt = VW'($urandom());
          2: amt = $urandom_range(0, 1) ? VW'(ACC_MAX) : VW'(ACC_MIN);
          3, 4: amt = lo_cur + VW'($urandom_range(0, 64)) - VW'(32);
          5, 6: amt = hi_cur + VW'($urandom_range(0, 64)) - VW'(32);
          7: amt = hi_cur - lo_cur + VW'($urandom_range(0, 20));   // step a whole window
          default: amt = VW'($urandom_range(0, 200)) - VW'(100);
        endcase
        send_word(mode, amt, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input words over %0d register writes, including clamp, wrap,",
             words_in, reg_writes);
    $display("zero, crossed and saturating bounds; checked %0d result words (%0d carries).",
             words_out, carries_seen);
    if (mismatches == 0 && words_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d result words still owed", mismatches, words_owed);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bacc_pkg.sv
design/bacc_ctrl.sv
design/bacc_dp.sv
design/bounded_accumulator_wrap_clamp.sv
tb/bounded_accumulator_wrap_clamp_test.sv
